[rtl/sbr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbr_pkg: shared types and constants of the serial-bus frame receiver
// Frame geometry, sync bytes, result kinds and the control structs that
// travel between the frame search and the result generator.
// ----------------------------------------------------------------------------
package sbr_pkg;

  localparam int BYTE_BITS    = 8;
  localparam int FRAME_BYTES  = 25;
  localparam int NUM_ANALOG   = 16;
  localparam int NUM_RESULTS  = 18;
  localparam int CH_BITS      = 11;
  localparam int IDX_BITS     = 5;
  localparam int STREAM_BITS  = NUM_ANALOG * CH_BITS;
  localparam int STREAM_BYTES = STREAM_BITS / BYTE_BITS;
  localparam int FLAG_BYTE    = 23;
  localparam int FLAG_HI_BIT  = 7;
  localparam int FLAG_LO_BIT  = 6;

  localparam logic [BYTE_BITS-1:0] SYNC_HEAD     = 8'h0F;
  localparam logic [BYTE_BITS-1:0] SYNC_TAIL     = 8'h00;
  localparam logic [BYTE_BITS-1:0] TIMEOUT_RESET = 8'd50;

  typedef enum logic {
    KIND_CHANNEL = 1'b0,
    KIND_TIMEOUT = 1'b1
  } kind_e;

  // Event raised by the search when it consumes a byte
  typedef struct packed {
    logic frame;
    logic timeout;
  } search_evt_t;

  // Payload of a found frame: packed channel bit stream and the two flags
  typedef struct packed {
    logic [STREAM_BITS-1:0] stream;
    logic [1:0]             flags;
  } frame_t;

endpackage

`default_nettype wire

[rtl/sbr_byte_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbr_byte_if: received byte channel
// Valid/ready channel that carries one serial byte per item.
// ----------------------------------------------------------------------------
interface sbr_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

[rtl/sbr_result_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbr_result_if: decoded result channel
// Valid/ready channel that carries one channel value or timeout per item.
// ----------------------------------------------------------------------------
interface sbr_result_if;
  logic          valid;
  logic          ready;
  sbr_pkg::kind_e kind;
  logic [4:0]    channel_index;
  logic [10:0]   channel_value;
  logic          last;

  modport source (output valid, output kind, output channel_index,
                  output channel_value, output last, input ready);
  modport sink (input valid, input kind, input channel_index,
                input channel_value, input last, output ready);
endinterface

`default_nettype wire

[rtl/sbr_frame_search.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbr_frame_search: byte window and sync search
// Registers each incoming byte; on consume it flags a frame or a timeout and
// clears the 25-byte window and count, or else shifts it into the window and counts it.
// ----------------------------------------------------------------------------
module sbr_frame_search (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  sbr_byte_if.sink             rx_i,
  input  logic                 cfg_we_i,
  input  logic [7:0]           cfg_wdata_i,
  input  logic                 gen_ready_i,
  output sbr_pkg::search_evt_t evt_o,
  output sbr_pkg::frame_t      frame_o
);
  import sbr_pkg::*;

  logic                 byte_valid_q;
  logic [BYTE_BITS-1:0] byte_q;
  logic [BYTE_BITS-1:0] win_q [FRAME_BYTES];
  logic [BYTE_BITS-1:0] count_q;
  logic [BYTE_BITS-1:0] limit_q;

  logic                 consume;
  logic [BYTE_BITS-1:0] count_inc;
  logic [BYTE_BITS-1:0] limit_eff;
  logic                 is_frame;
  logic                 is_timeout;

  // Hand the held byte to the window when the generator can take an event
  assign consume     = byte_valid_q && gen_ready_i;
  assign rx_i.ready  = !byte_valid_q || consume;

  // Saturating count and the effective limit (zero acts as one)
  assign count_inc  = (count_q == '1) ? count_q : count_q + BYTE_BITS'(1);
  assign limit_eff  = (limit_q == '0) ? BYTE_BITS'(1) : limit_q;

  // After the shift the oldest byte is win_q[1] and the newest is byte_q
  assign is_frame   = (win_q[1] == SYNC_HEAD) && (byte_q == SYNC_TAIL);
  assign is_timeout = !is_frame && (count_inc >= limit_eff);

  assign evt_o.frame   = consume && is_frame;
  assign evt_o.timeout = consume && is_timeout;

  // Gather frame payload from the window as it stands after the shift
  always_comb begin
    for (int i = 0; i < STREAM_BYTES; i++) begin
      frame_o.stream[i*BYTE_BITS +: BYTE_BITS] = win_q[i+2];
    end
    frame_o.flags = {win_q[FLAG_BYTE+1][FLAG_HI_BIT], win_q[FLAG_BYTE+1][FLAG_LO_BIT]};
  end

  // Input register: hold one byte until consumed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_valid_q <= 1'b0;
    end else if (rx_i.valid && rx_i.ready) begin
      byte_valid_q <= 1'b1;
    end else if (consume) begin
      byte_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.valid && rx_i.ready) begin
      byte_q <= rx_i.rx_byte;
    end
  end

  // Window and count: clear after an event, otherwise shift and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < FRAME_BYTES; i++) begin
        win_q[i] <= '0;
      end
      count_q <= '0;
    end else if (consume) begin
      if (is_frame || is_timeout) begin
        for (int i = 0; i < FRAME_BYTES; i++) begin
          win_q[i] <= '0;
        end
        count_q <= '0;
      end else begin
        for (int i = 0; i < FRAME_BYTES - 1; i++) begin
          win_q[i] <= win_q[i+1];
        end
        win_q[FRAME_BYTES-1] <= byte_q;
        count_q              <= count_inc;
      end
    end
  end

  // Timeout limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= TIMEOUT_RESET;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

endmodule

`default_nettype wire

[rtl/sbr_result_gen.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbr_result_gen: result burst generator and output register
// Holds a found frame and sends its 18 channel items one per cycle while res_o
// is ready, or sends a single timeout item, through a registered output stage.
// ----------------------------------------------------------------------------
module sbr_result_gen (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  sbr_pkg::search_evt_t evt_i,
  input  sbr_pkg::frame_t      frame_i,
  output logic                 gen_ready_o,
  sbr_result_if.source         res_o
);
  import sbr_pkg::*;

  localparam int ANA_W = $clog2(NUM_ANALOG);

  frame_t                frame_q;
  logic                  burst_q;
  logic [IDX_BITS-1:0]   idx_q;

  logic                  out_valid_q;
  kind_e                 out_kind_q;
  logic [IDX_BITS-1:0]   out_idx_q;
  logic [CH_BITS-1:0]    out_value_q;
  logic                  out_last_q;

  logic                  out_free;
  logic                  idx_is_last;
  logic [CH_BITS-1:0]    chan [NUM_ANALOG];
  logic [CH_BITS-1:0]    burst_value;

  assign out_free    = !out_valid_q || res_o.ready;
  assign gen_ready_o = !burst_q && out_free;
  assign idx_is_last = (idx_q == IDX_BITS'(NUM_RESULTS - 1));

  // Split the stored stream into analog channels
  always_comb begin
    for (int k = 0; k < NUM_ANALOG; k++) begin
      chan[k] = frame_q.stream[k*CH_BITS +: CH_BITS];
    end
  end

  // Select the value of the current burst item
  always_comb begin
    if (idx_q < IDX_BITS'(NUM_ANALOG)) begin
      burst_value = chan[idx_q[ANA_W-1:0]];
    end else if (idx_q == IDX_BITS'(NUM_ANALOG)) begin
      burst_value = CH_BITS'(frame_q.flags[1]);
    end else begin
      burst_value = CH_BITS'(frame_q.flags[0]);
    end
  end

  // Capture the frame payload when a frame is found
  always_ff @(posedge clk_i) begin
    if (evt_i.frame) begin
      frame_q <= frame_i;
    end
  end

  // Burst control and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      burst_q     <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (evt_i.frame) begin
      burst_q     <= 1'b1;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (evt_i.timeout) begin
      out_valid_q <= 1'b1;
    end else if (burst_q && out_free) begin
      out_valid_q <= 1'b1;
      idx_q       <= idx_q + IDX_BITS'(1);
      if (idx_is_last) begin
        burst_q <= 1'b0;
      end
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (evt_i.timeout) begin
      out_kind_q  <= KIND_TIMEOUT;
      out_idx_q   <= '0;
      out_value_q <= '0;
      out_last_q  <= 1'b1;
    end else if (!evt_i.frame && burst_q && out_free) begin
      out_kind_q  <= KIND_CHANNEL;
      out_idx_q   <= idx_q;
      out_value_q <= burst_value;
      out_last_q  <= idx_is_last;
    end
  end

  assign res_o.valid         = out_valid_q;
  assign res_o.kind          = out_kind_q;
  assign res_o.channel_index = out_idx_q;
  assign res_o.channel_value = out_value_q;
  assign res_o.last          = out_last_q;

endmodule

`default_nettype wire

[rtl/sbus_frame_receiver.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbus_frame_receiver: 25-byte serial-bus frame receiver
// Searches a byte stream for frames and unpacks them into channel items.
// ----------------------------------------------------------------------------
// Usage:
//   rx_i carries received bytes, res_o carries decoded items; both are
//   valid/ready channels, an item moves when valid and ready are high.
//   cfg_we_i/cfg_wdata_i write the timeout limit (bytes searched without a
//   frame before a timeout item); write it only while the block is idle.
//   A byte is taken into an input register, then shifted into the window
//   once the result generator can take an event. A timeout item passes the
//   input and output registers to res_o. For a frame, the generator holds
//   the payload and sends the 18 channel items through the output register,
//   one per cycle while res_o is ready; the last one has last set. Bytes
//   stream in at one per cycle while the generator is ready; during a frame
//   burst it is busy, so input stalls once the input register holds a byte.
//   Reset clears the window, the search count and all valid flags and sets
//   the timeout limit to 50.
//   When res_o stalls, the output register holds its item and the input
//   keeps one byte buffered before deasserting ready.
// ----------------------------------------------------------------------------
module sbus_frame_receiver (
  input  logic       clk_i,
  input  logic       rst_ni,
  sbr_byte_if.sink   rx_i,
  sbr_result_if.source res_o,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i
);
  import sbr_pkg::*;

  search_evt_t evt;
  frame_t      frame;
  logic        gen_ready;

  sbr_frame_search u_search (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rx_i        (rx_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .gen_ready_i (gen_ready),
    .evt_o       (evt),
    .frame_o     (frame)
  );

  sbr_result_gen u_gen (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .evt_i       (evt),
    .frame_i     (frame),
    .gen_ready_o (gen_ready),
    .res_o       (res_o)
  );

endmodule

`default_nettype wire

[rtl/sbr_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbr_checker: port-level checks of the frame receiver
// Watches the result channel for burst ordering and result coding.
// ----------------------------------------------------------------------------
module sbr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        res_valid,
  input logic        res_ready,
  input logic        res_kind,
  input logic [4:0]  res_index,
  input logic [10:0] res_value,
  input logic        res_last
);
  import sbr_pkg::*;

  // Hold a stalled item
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_ready |=> res_valid && $stable(res_index)
      && $stable(res_value) && $stable(res_kind) && $stable(res_last))
    else $error("result changed while stalled");

  // Timeout item is a single, zeroed, last item
  a_timeout_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && res_kind == KIND_TIMEOUT |->
      res_last && res_index == '0 && res_value == '0)
    else $error("malformed timeout item");

  // Last flag marks exactly the final channel of a frame
  a_last_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && res_kind == KIND_CHANNEL |->
      res_last == (res_index == 5'(NUM_RESULTS - 1)))
    else $error("last flag does not match channel index");

  // Frame burst runs without gaps
  a_burst_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && res_ready && res_kind == KIND_CHANNEL && !res_last |=>
      res_valid && res_kind == KIND_CHANNEL && res_index == $past(res_index) + 5'd1)
    else $error("frame burst broken");

  // Flag channels carry one bit
  a_flag_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && res_kind == KIND_CHANNEL && res_index >= 5'(NUM_ANALOG) |->
      res_value[10:1] == '0)
    else $error("flag channel wider than one bit");

endmodule

bind sbus_frame_receiver sbr_checker u_sbr_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .res_valid (res_o.valid),
  .res_ready (res_o.ready),
  .res_kind  (res_o.kind),
  .res_index (res_o.channel_index),
  .res_value (res_o.channel_value),
  .res_last  (res_o.last)
);

`default_nettype wire
